// ----- hdl/bsd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsd_pkg: shared types and constants for the block sum downsampler
// Request layouts, configuration register indexes, field widths and the
// fixed-point scale used to divide by the block factor.
// ----------------------------------------------------------------------------
package bsd_pkg;

  // Field widths fixed by the stream format
  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 22;
  localparam int IDX_OUT_W = 9;
  localparam int SIDE_W    = 11;
  localparam int FACT_CFG_W = 4;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  // Reciprocal scale for division by the block factor: exact for
  // dividends below 4096 and divisors up to 16.
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W     = 18;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_SIDE   = 1024;
  localparam int DEF_MAX_FACTOR = 8;

  // Register values after reset
  localparam int RST_SIDE   = 4;
  localparam int RST_FACTOR = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIDE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_FACTOR = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       matrix_start;
  } sample_req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]   block_sum;
    logic [IDX_OUT_W-1:0]      block_row;
    logic [IDX_OUT_W-1:0]      block_col;
    logic                      last_block;
  } result_req_t;

endpackage
`default_nettype wire

// ----- hdl/block_sum_downsampler_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_sum_downsampler_top: k-by-k sum pooling of a square raster matrix
// Sums each non-overlapping k x k block of a row-major sample stream and
// emits one request per completed block.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel (sample_valid / sample_ready / sample) takes one matrix
//   element per request; matrix_start restarts the raster at that element.
//   Result channel (result_valid / result_ready / result) carries the block
//   sum, its block row and column and a mark on the final block.
//   Configuration: cfg_we with cfg_index selects matrix_side (index 0) or
//   block_factor (index 1); out-of-range values are clamped on write.
//   Throughput: one sample per cycle while the result side does not stall.
//   A result passes the fold-stage registers and then the output register
//   after the sample that completes its block (accept stage computes the
//   position, block indexes by reciprocal multiply and the column-sum memory
//   read; the second stage adds and writes back or loads the output register).
//   Stall: while result_valid is high and result_ready low, the whole
//   pipeline holds and sample_ready stays low.
//   Reset: position counters, running sum and pipeline valids clear,
//   registers return to side 4 and factor 2. The column-sum memory is not
//   cleared; each block row writes its entries before reading them.
// ----------------------------------------------------------------------------
module block_sum_downsampler_top #(
  parameter int MAX_SIDE   = bsd_pkg::DEF_MAX_SIDE,
  parameter int MAX_FACTOR = bsd_pkg::DEF_MAX_FACTOR
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            sample_valid,
  output logic                                 sample_ready,
  input  wire bsd_pkg::sample_req_t            sample,
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output bsd_pkg::result_req_t                 result,
  input  wire logic                            cfg_we,
  input  wire logic [bsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bsd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CNT_W   = $clog2(MAX_SIDE);
  localparam int FACT_W  = $clog2(MAX_FACTOR + 1);
  localparam int SLOTS   = MAX_SIDE / 2;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int SIDE_W  = bsd_pkg::SIDE_W;
  localparam int SUM_W   = bsd_pkg::SUM_W;
  localparam int SMP_W   = bsd_pkg::SAMPLE_W;
  localparam int RCP_W   = bsd_pkg::RECIP_W;
  localparam int RCP_SH  = bsd_pkg::RECIP_SHIFT;
  localparam int IDX_W   = bsd_pkg::IDX_OUT_W;

  // Reciprocal table: ceil(2^RCP_SH / k) for every legal factor
  logic [RCP_W-1:0] recip_tab [MAX_FACTOR+1];
  for (genvar kk = 0; kk <= MAX_FACTOR; kk++) begin : g_recip
    localparam int DIV = (kk < 2) ? 2 : kk;
    localparam int RV  = ((1 << RCP_SH) + DIV - 1) / DIV;
    assign recip_tab[kk] = RCP_W'(RV);
  end

  // ---------------------------------------------------------------- config
  logic [SIDE_W-1:0] side_eff;
  logic [FACT_W-1:0] k_eff;
  logic [RCP_W-1:0]  k_recip;
  logic [SIDE_W-1:0] nb;          // blocks per side

  logic [SIDE_W-1:0] side_wr;
  logic [FACT_W-1:0] k_wr;
  logic [SIDE_W-1:0] side_sel;
  logic [RCP_W-1:0]  recip_sel;
  logic [SIDE_W+RCP_W-1:0] nb_prod;
  logic [SIDE_W-1:0] nb_next;

  always_comb begin
    // Clamp the written values into the supported range
    side_wr = cfg_data[SIDE_W-1:0];
    if (side_wr < SIDE_W'(2)) begin
      side_wr = SIDE_W'(2);
    end else if (32'(side_wr) > MAX_SIDE) begin
      side_wr = SIDE_W'(MAX_SIDE);
    end
    if (cfg_data[bsd_pkg::FACT_CFG_W-1:0] < 4'd2) begin
      k_wr = FACT_W'(2);
    end else if (32'(cfg_data[bsd_pkg::FACT_CFG_W-1:0]) > MAX_FACTOR) begin
      k_wr = FACT_W'(MAX_FACTOR);
    end else begin
      k_wr = FACT_W'(cfg_data[bsd_pkg::FACT_CFG_W-1:0]);
    end
    side_sel  = (cfg_index == bsd_pkg::REG_MATRIX_SIDE) ? side_wr : side_eff;
    recip_sel = (cfg_index == bsd_pkg::REG_BLOCK_FACTOR) ? recip_tab[k_wr] : k_recip;
    nb_prod   = (SIDE_W+RCP_W)'(side_sel) * (SIDE_W+RCP_W)'(recip_sel);
    nb_next   = nb_prod[RCP_SH +: SIDE_W];
  end

  // ------------------------------------------------------ accept stage
  logic [CNT_W-1:0]  row_counter;
  logic [CNT_W-1:0]  column_counter;
  logic [FACT_W-1:0] row_in_block;
  logic [FACT_W-1:0] col_in_block;
  logic [SUM_W-1:0]  running_row_sum;

  logic [CNT_W-1:0]  row_counter_next;
  logic [CNT_W-1:0]  column_counter_next;
  logic [FACT_W-1:0] row_in_block_next;
  logic [FACT_W-1:0] col_in_block_next;
  logic [SUM_W-1:0]  running_row_sum_next;

  logic              advance;
  logic              accept;

  logic [CNT_W-1:0]  r;
  logic [CNT_W-1:0]  c;
  logic [FACT_W-1:0] rib;
  logic [FACT_W-1:0] cib;
  logic [SUM_W-1:0]  run;
  logic [CNT_W+RCP_W-1:0] br_prod;
  logic [CNT_W+RCP_W-1:0] bc_prod;
  logic [CNT_W-1:0]  br;
  logic [CNT_W-1:0]  bc;
  logic              in_area;
  logic              col_end;
  logic [SUM_W-1:0]  smp_ext;
  logic [SUM_W-1:0]  acc;
  logic              emit_blk;   // block column done: fold or emit

  // Second-stage registers
  logic              p_valid;
  logic [SUM_W-1:0]  p_acc;
  logic [CNT_W-1:0]  p_br;
  logic [CNT_W-1:0]  p_bc;
  logic              p_row_first;
  logic              p_row_end;
  logic              p_last;
  logic [SUM_W-1:0]  col_rd;

  logic [SUM_W-1:0]  column_partial_sums [SLOTS];

  assign advance      = !result_valid || result_ready;
  assign sample_ready = advance;
  assign accept       = sample_valid && sample_ready;

  always_comb begin
    // Restart the raster on a start flag
    if (sample.matrix_start) begin
      r   = '0;
      c   = '0;
      rib = '0;
      cib = '0;
      run = '0;
    end else begin
      r   = row_counter;
      c   = column_counter;
      rib = row_in_block;
      cib = col_in_block;
      run = running_row_sum;
    end

    br_prod = (CNT_W+RCP_W)'(r) * (CNT_W+RCP_W)'(k_recip);
    bc_prod = (CNT_W+RCP_W)'(c) * (CNT_W+RCP_W)'(k_recip);
    br      = br_prod[RCP_SH +: CNT_W];
    bc      = bc_prod[RCP_SH +: CNT_W];
    in_area = ((SIDE_W+CNT_W)'(br) < (SIDE_W+CNT_W)'(nb))
           && ((SIDE_W+CNT_W)'(bc) < (SIDE_W+CNT_W)'(nb));

    smp_ext = {{(SUM_W-SMP_W){sample.sample_value[SMP_W-1]}}, sample.sample_value};
    acc     = ((cib == '0) ? '0 : run) + smp_ext;
    col_end = ((FACT_W+1)'(cib) + (FACT_W+1)'(1)) >= (FACT_W+1)'(k_eff);
    emit_blk = in_area && col_end;

    row_counter_next     = r;
    row_in_block_next    = rib;
    col_in_block_next    = cib;
    running_row_sum_next = run;

    if (in_area) begin
      if (col_end) begin
        col_in_block_next    = '0;
        running_row_sum_next = '0;
      end else begin
        col_in_block_next    = cib + FACT_W'(1);
        running_row_sum_next = acc;
      end
    end

    // Advance the raster position; wrap at row and matrix ends
    if (((SIDE_W+CNT_W)'(c) + (SIDE_W+CNT_W)'(1)) >= (SIDE_W+CNT_W)'(side_eff)) begin
      column_counter_next  = '0;
      col_in_block_next    = '0;
      running_row_sum_next = '0;
      if (((SIDE_W+CNT_W)'(r) + (SIDE_W+CNT_W)'(1)) >= (SIDE_W+CNT_W)'(side_eff)) begin
        row_counter_next  = '0;
        row_in_block_next = '0;
      end else begin
        row_counter_next  = r + CNT_W'(1);
        row_in_block_next = (((FACT_W+1)'(rib) + (FACT_W+1)'(1)) >= (FACT_W+1)'(k_eff))
                          ? '0 : rib + FACT_W'(1);
      end
    end else begin
      column_counter_next = c + CNT_W'(1);
    end
  end

  // ------------------------------------------------------ fold stage
  logic [SUM_W-1:0] total;
  logic [CNT_W+IDX_W-1:0] br_out;
  logic [CNT_W+IDX_W-1:0] bc_out;

  assign total  = (p_row_first ? '0 : col_rd) + p_acc;
  assign br_out = (CNT_W+IDX_W)'(p_br);
  assign bc_out = (CNT_W+IDX_W)'(p_bc);

  // Column-sum memory: read at accept, write back from the fold stage
  always_ff @(posedge clk) begin
    if (accept) begin
      col_rd <= column_partial_sums[bc[SLOT_W-1:0]];
    end
    if (advance && p_valid && !p_row_end) begin
      column_partial_sums[p_bc[SLOT_W-1:0]] <= total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_eff        <= SIDE_W'(bsd_pkg::RST_SIDE);
      k_eff           <= FACT_W'(bsd_pkg::RST_FACTOR);
      k_recip         <= recip_tab[FACT_W'(bsd_pkg::RST_FACTOR)];
      nb              <= SIDE_W'(bsd_pkg::RST_SIDE / bsd_pkg::RST_FACTOR);
      row_counter     <= '0;
      column_counter  <= '0;
      row_in_block    <= '0;
      col_in_block    <= '0;
      running_row_sum <= '0;
      p_valid         <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bsd_pkg::REG_MATRIX_SIDE: begin
            side_eff <= side_wr;
          end
          bsd_pkg::REG_BLOCK_FACTOR: begin
            k_eff   <= k_wr;
            k_recip <= recip_tab[k_wr];
          end
          default: begin
          end
        endcase
        nb <= nb_next;
      end

      if (accept) begin
        row_counter     <= row_counter_next;
        column_counter  <= column_counter_next;
        row_in_block    <= row_in_block_next;
        col_in_block    <= col_in_block_next;
        running_row_sum <= running_row_sum_next;
      end

      if (advance) begin
        p_valid      <= accept && emit_blk;
        result_valid <= p_valid && p_row_end;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      p_acc       <= acc;
      p_br        <= br;
      p_bc        <= bc;
      p_row_first <= (rib == '0);
      p_row_end   <= ((FACT_W+1)'(rib) + (FACT_W+1)'(1)) >= (FACT_W+1)'(k_eff);
      p_last      <= ((SIDE_W+CNT_W)'(br) + (SIDE_W+CNT_W)'(1) == (SIDE_W+CNT_W)'(nb))
                  && ((SIDE_W+CNT_W)'(bc) + (SIDE_W+CNT_W)'(1) == (SIDE_W+CNT_W)'(nb));
      if (p_valid && p_row_end) begin
        result.block_sum  <= total;
        result.block_row  <= br_out[IDX_W-1:0];
        result.block_col  <= bc_out[IDX_W-1:0];
        result.last_block <= p_last;
      end
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/block_sum_downsampler_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_sum_downsampler_top_test: self-checking bench for k-by-k sum pooling
// Streams square sample matrices through the block, predicts every block sum
// with a behavioral model of the raster walk, and compares each result
// request field by field. Covers reset settings, clamped registers, side
// below factor, restarts, wrap-around, 1024-wide rows, sum extremes, a long
// result stall and random matrices under random idling on both channels.
// ----------------------------------------------------------------------------
module block_sum_downsampler_top_test;

  localparam int SAMPLE_W       = bsd_pkg::SAMPLE_W;
  localparam int SUM_W          = bsd_pkg::SUM_W;
  localparam int SIDE_W         = bsd_pkg::SIDE_W;
  localparam int FACT_CFG_W     = bsd_pkg::FACT_CFG_W;
  localparam int IDX_OUT_W      = bsd_pkg::IDX_OUT_W;
  localparam int CFG_IDX_W      = bsd_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W     = bsd_pkg::CFG_DATA_W;
  localparam int DEF_MAX_SIDE   = bsd_pkg::DEF_MAX_SIDE;
  localparam int DEF_MAX_FACTOR = bsd_pkg::DEF_MAX_FACTOR;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 240;
  // The block answers through its fold and output registers; leave margin.
  localparam int DRAIN_SLACK  = 6;
  localparam int END_SLACK    = 10;
  localparam int HOLD_LENGTH  = 300;
  localparam int REPORT_LIMIT = 10;
  localparam int COL_SLOTS    = DEF_MAX_SIDE / 2;
  localparam int SLOT_W       = $clog2(COL_SLOTS);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // How the samples of one matrix are filled
  typedef enum int {
    FILL_RANDOM,
    FILL_MAX,
    FILL_MIN,
    FILL_EXTREMES,
    FILL_SMALL
  } fill_t;

  logic                   clk;
  logic                   rst;
  logic                   sample_valid;
  logic                   sample_ready;
  bsd_pkg::sample_req_t   sample;
  logic                   result_valid;
  logic                   result_ready;
  bsd_pkg::result_req_t   result;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  block_sum_downsampler_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  int unsigned cycle_count      = 0;
  int unsigned mismatch_count   = 0;
  int unsigned samples_sent     = 0;
  int unsigned sums_checked     = 0;
  int unsigned settings_written = 0;
  int unsigned hold_cycles      = 0;
  bit          steady_stream    = 1'b0;

  // Predicted pooling state: raw register values and the raster position
  logic [SIDE_W-1:0]       side_setting   = SIDE_W'(bsd_pkg::RST_SIDE);
  logic [FACT_CFG_W-1:0]   factor_setting = FACT_CFG_W'(bsd_pkg::RST_FACTOR);
  logic signed [SUM_W-1:0] column_sums [COL_SLOTS];
  logic signed [SUM_W-1:0] row_total = '0;
  int unsigned             row_pos   = 0;
  int unsigned             col_pos   = 0;
  int unsigned             row_phase = 0;
  int unsigned             col_phase = 0;
  bsd_pkg::result_req_t    expected_sums [$];

  // --------------------------------------------------------------------------
  // Clock, cycle counter and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Abort a hung run; the limit is many times the slowest correct run.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d block sums still pending",
             cycle_count, expected_sums.size());
    $display("block_sum_downsampler_top regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Pooling predictor: walk the raster exactly as the block should and queue
  // one expected block sum per completed k x k block.
  // --------------------------------------------------------------------------
  function automatic void predict_sample(bsd_pkg::sample_req_t req);
    int unsigned             side;
    int unsigned             k;
    int unsigned             blocks;
    int unsigned             span;
    int unsigned             br;
    int unsigned             bc;
    logic signed [SUM_W-1:0] value;
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] prior;
    logic signed [SUM_W-1:0] total;
    bsd_pkg::result_req_t    sum_out;

    // Clamp the registers at use; out-of-range writes act as the nearest bound
    side = 32'(side_setting);
    if (side < 2) side = 2;
    if (side > DEF_MAX_SIDE) side = DEF_MAX_SIDE;
    k = 32'(factor_setting);
    if (k < 2) k = 2;
    if (k > DEF_MAX_FACTOR) k = DEF_MAX_FACTOR;
    blocks = side / k;
    span   = blocks * k;
    value  = {{(SUM_W - SAMPLE_W){req.sample_value[SAMPLE_W-1]}}, req.sample_value};

    // A start flag restarts the raster at this very sample
    if (req.matrix_start) begin
      row_total = '0;
      row_pos   = 0;
      col_pos   = 0;
      row_phase = 0;
      col_phase = 0;
    end

    // Trailing rows and columns outside the last whole block are skipped
    if (row_pos < span && col_pos < span) begin
      acc = value;
      if (col_phase != 0) acc = acc + row_total;
      if (col_phase + 1 >= k) begin
        bc    = col_pos / k;
        br    = row_pos / k;
        prior = '0;
        if (row_phase != 0 && bc < COL_SLOTS) prior = column_sums[SLOT_W'(bc)];
        total = prior + acc;
        if (row_phase + 1 >= k) begin
          sum_out.block_sum  = total;
          sum_out.block_row  = IDX_OUT_W'(br);
          sum_out.block_col  = IDX_OUT_W'(bc);
          sum_out.last_block = (br == blocks - 1) && (bc == blocks - 1);
          expected_sums.push_back(sum_out);
        end else if (bc < COL_SLOTS) begin
          column_sums[SLOT_W'(bc)] = total;
        end
        col_phase = 0;
        row_total = '0;
      end else begin
        col_phase = col_phase + 1;
        row_total = acc;
      end
    end

    // Advance the position; wrap to the origin after the last sample
    if (col_pos + 1 >= side) begin
      col_pos   = 0;
      col_phase = 0;
      row_total = '0;
      if (row_pos + 1 >= side) begin
        row_pos   = 0;
        row_phase = 0;
      end else begin
        row_pos   = row_pos + 1;
        row_phase = (row_phase + 1 >= k) ? 0 : row_phase + 1;
      end
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(fill_t style);
    logic signed [SAMPLE_W-1:0] v;
    v = SAMPLE_W'($urandom);
    case (style)
      FILL_MAX:      v = SAMPLE_MAX;
      FILL_MIN:      v = SAMPLE_MIN;
      FILL_EXTREMES: v = ($urandom_range(0, 1) == 0) ? SAMPLE_MAX : SAMPLE_MIN;
      FILL_SMALL:    v = SAMPLE_W'($urandom_range(0, 15)) - 16'sd8;
      default:       v = SAMPLE_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic void report_mismatch(string what, bsd_pkg::result_req_t want,
                                          bsd_pkg::result_req_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("MISMATCH (%s) cycle %0d: expected sum %0d row %0d col %0d last %0b,",
               what, cycle_count, want.block_sum, want.block_row, want.block_col,
               want.last_block);
      $display("  got sum %0d row %0d col %0d last %0b",
               got.block_sum, got.block_row, got.block_col, got.last_block);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: drive ready with random stall bursts, honor a requested long
  // hold, and check every accepted result request against the oldest
  // expected block sum.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned quiet;
    quiet = 0;
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        // Long hold: let the pipeline fill and back up into the sample side
        hold_cycles = hold_cycles - 1;
        result_ready <= 1'b0;
      end else if (steady_stream) begin
        result_ready <= 1'b1;
      end else if (quiet != 0) begin
        quiet = quiet - 1;
        result_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        quiet = $urandom_range(0, 4);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Values read right after the edge are the ones the edge saw
  always @(posedge clk) begin : check_results
    bsd_pkg::result_req_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_sums.size() == 0) begin
        want = '0;
        report_mismatch("no block sum pending", want, result);
      end else begin
        want = expected_sums.pop_front();
        sums_checked++;
        if (result.block_sum !== want.block_sum || result.block_row !== want.block_row ||
            result.block_col !== want.block_col ||
            result.last_block !== want.last_block) begin
          report_mismatch("field", want, result);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sample side
  // --------------------------------------------------------------------------
  // Offer one sample request and hold it until accepted. Here valid is only
  // dropped when an idle burst is inserted, never between back-to-back items.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic start);
    bsd_pkg::sample_req_t req;
    req.sample_value = value;
    req.matrix_start = start;
    if (!steady_stream && $urandom_range(0, 5) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= req;
    do @(posedge clk); while (!sample_ready);
    predict_sample(req);
    samples_sent++;
  endtask

  // Drop valid, wait for every pending block sum, then give the pipeline
  // time to finish samples that produce no result.
  task automatic settle_block();
    sample_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Write one register; only called while the block is idle
  task automatic write_register(input logic [CFG_IDX_W-1:0] index, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    if (index == bsd_pkg::REG_MATRIX_SIDE) side_setting = SIDE_W'(value);
    else factor_setting = FACT_CFG_W'(value);
    settings_written++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input int unsigned side, input int unsigned factor);
    settle_block();
    write_register(bsd_pkg::REG_MATRIX_SIDE, side);
    write_register(bsd_pkg::REG_BLOCK_FACTOR, factor);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset settings (side 4, factor 2): run a whole matrix from the reset
  // position, wrap into the next one, then restart it mid-row.
  task automatic test_reset_settings();
    int i;
    for (i = 0; i < 16; i++) begin
      send_sample((i % 3 == 0) ? SAMPLE_MAX : (i % 3 == 1) ? SAMPLE_MIN : SAMPLE_W'(i), 1'b0);
    end
    for (i = 0; i < 3; i++) send_sample(SAMPLE_W'(-i), 1'b0);
    for (i = 0; i < 6; i++) send_sample(pick_sample(FILL_RANDOM), i == 0);
  endtask

  // Out-of-range registers clamp; full-size blocks reach both sum extremes;
  // a side below the factor produces nothing.
  task automatic test_clamped_settings();
    int i;
    apply_settings(0, 1);
    for (i = 0; i < 4; i++) send_sample(pick_sample(FILL_EXTREMES), i == 0);
    apply_settings(8, 15);
    for (i = 0; i < 64; i++) send_sample(SAMPLE_MIN, i == 0);
    settle_block();
    write_register(bsd_pkg::REG_BLOCK_FACTOR, 9);
    for (i = 0; i < 64; i++) send_sample(SAMPLE_MAX, i == 0);
    apply_settings(3, 4);
    for (i = 0; i < 9; i++) send_sample(pick_sample(FILL_RANDOM), i == 0);
  endtask

  // Side register all ones clamps to the widest raster; one full row writes
  // every column partial sum, and the first block only completes if the row
  // wraps at the clamped side.
  task automatic test_wide_rows();
    int i;
    apply_settings(2047, 2);
    for (i = 0; i < DEF_MAX_SIDE + 2; i++) send_sample(pick_sample(FILL_RANDOM), i == 0);
  endtask

  // Hold the result side off for a long stretch while samples keep coming,
  // so the block fills up and stalls its sample side.
  task automatic test_result_stall();
    int i;
    apply_settings(4, 2);
    hold_cycles = HOLD_LENGTH;
    for (i = 0; i < 48; i++) send_sample(pick_sample(FILL_RANDOM), i == 0);
  endtask

  // Random settings and matrices: mostly whole matrices with random content,
  // some cut short, some restarted mid-way, some wrapping without a flag.
  task automatic test_random_matrices();
    int unsigned side;
    int unsigned factor;
    int unsigned side_eff;
    int unsigned count;
    int unsigned sent;
    int unsigned i;
    fill_t       style;
    bit          need_start;
    bit          start;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       side = $urandom_range(0, 1);
        1:       side = $urandom_range(13, 20);
        default: side = $urandom_range(2, 12);
      endcase
      factor = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 8);
      apply_settings(side, factor);
      side_eff   = (side < 2) ? 2 : side;
      need_start = 1'b1;
      repeat ($urandom_range(1, 3)) begin
        count = side_eff * side_eff;
        if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
        style = ($urandom_range(0, 1) == 0) ? FILL_RANDOM : fill_t'($urandom_range(1, 4));
        for (i = 0; i < count; i++) begin
          start = (i == 0) ? (need_start || $urandom_range(0, 3) != 0)
                           : ($urandom_range(0, 63) == 0);
          send_sample(pick_sample(style), start);
          need_start = 1'b0;
          sent++;
        end
      end
    end
  endtask

  // Full rate on both sides for the closing matrices
  task automatic test_steady_stream();
    int i;
    apply_settings(6, 3);
    steady_stream = 1'b1;
    for (i = 0; i < 108; i++) send_sample(pick_sample(FILL_RANDOM), i == 0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample       <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_settings();
    test_clamped_settings();
    test_wide_rows();
    test_result_stall();
    test_random_matrices();
    test_steady_stream();

    settle_block();
    repeat (END_SLACK) @(posedge clk);

    $display("Sent %0d sample requests, checked %0d block sums, %0d register writes.",
             samples_sent, sums_checked, settings_written);
    $display("Covered clamping, side below factor, restarts, wrap, wide rows, extremes, stall.");
    if (mismatch_count == 0 && expected_sums.size() == 0) begin
      $display("block_sum_downsampler_top regression: pass");
    end else begin
      $display("block_sum_downsampler_top regression: fail");
    end
    $finish;
  end

endmodule
